[hw/rtl/i2c_master_controller_core_macros.svh]
// ---------------------------------------------------------------------------
// I2C master controller assertion macros
// Concurrent assertion helpers, clocked on aclk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef I2C_MASTER_CONTROLLER_CORE_MACROS_SVH
`define I2C_MASTER_CONTROLLER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Check that an expression holds at every clock edge
`define I2CM_ASSERT(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);
// Check that a condition implies a consequence at the next clock edge
`define I2CM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define I2CM_ASSERT(label, expr, msg)
`define I2CM_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

[hw/rtl/i2cm_pkg.sv]
// ---------------------------------------------------------------------------
// I2C master controller package
// Sequencer states, command codes, line drive bits and result layout.
// ---------------------------------------------------------------------------
`default_nettype none

package i2cm_pkg;

    // Sequencer states: idle, then one per kind of SCL half period in a sequence
    typedef enum logic [3:0] {
        ST_IDLE    = 4'd0,
        ST_START_A = 4'd1,
        ST_START_B = 4'd2,
        ST_RS_A    = 4'd3,
        ST_RS_B    = 4'd4,
        ST_RS_C    = 4'd5,
        ST_STOP_A  = 4'd6,
        ST_STOP_B  = 4'd7,
        ST_STOP_C  = 4'd8,
        ST_WR_LOW  = 4'd9,
        ST_WR_HIGH = 4'd10,
        ST_RD_LOW  = 4'd11,
        ST_RD_HIGH = 4'd12
    } seq_state_t;

    // Command codes
    localparam logic [2:0] OP_START     = 3'd0;
    localparam logic [2:0] OP_RESTART   = 3'd1;
    localparam logic [2:0] OP_STOP      = 3'd2;
    localparam logic [2:0] OP_WRITE     = 3'd3;
    localparam logic [2:0] OP_READ_ACK  = 3'd4;
    localparam logic [2:0] OP_READ_NACK = 3'd5;

    // Configuration register indexes
    localparam logic [1:0] CFG_CLOCK_DIVIDER = 2'd0;
    localparam logic [1:0] CFG_ENABLE        = 2'd1;

    localparam logic [7:0] DIVIDER_RESET = 8'd49;
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    // Line drive bits: bit 0 pulls SCL low, bit 1 pulls SDA low
    localparam logic [1:0] LD_NONE = 2'b00;
    localparam logic [1:0] LD_SCL  = 2'b01;
    localparam logic [1:0] LD_SDA  = 2'b10;
    localparam logic [1:0] LD_BOTH = 2'b11;

    // Result layout, lowest bit last
    typedef struct packed {
        logic [1:0] pad;
        logic       command_rejected;
        logic [7:0] read_data;
        logic       not_acknowledged;
        logic       done_res;
        logic       busy_res;
        logic       sda_drive_low;
        logic       scl_drive_low;
    } result_t;

endpackage

`default_nettype wire

[hw/rtl/i2c_master_controller_core.sv]
// ---------------------------------------------------------------------------
// I2C master controller core
// Single-master I2C sequencer advanced by one tick per input request.
// ---------------------------------------------------------------------------
//  Channel | Direction | Contents
//  s_      | in        | tuser: cmd_valid, operation; tdata: write_data, sda_in
//  m_      | out       | tdata: line drive, busy, done, nack, read_data, reject
//  cfg_    | in        | index 0 clock_divider, index 1 enable
//
//  One tick per request; a request is taken every cycle that s_tready is high,
//  and its result is registered as it is taken. The sequencer state is updated
//  by a single pass of logic per tick. A two-entry output stage (register plus
//  skid) lets one more request in while a result waits; s_tready drops only
//  when both entries are full. Synchronous reset gives no clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none
`include "i2c_master_controller_core_macros.svh"

module i2c_master_controller_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input ticks
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [7:0] write_data, [8] sda_in, [15:9] zero
    input  wire logic [3:0]  s_tuser,   // [0] cmd_valid, [3:1] operation
    // results
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0] m_tdata,        // [0] scl_drive_low, [1] sda_drive_low,
                                        // [2] busy_res, [3] done_res,
                                        // [4] not_acknowledged, [12:5] read_data,
                                        // [13] command_rejected, [15:14] zero
    // configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);

    // Configuration registers
    logic [7:0] divider_reg;
    logic       enable_reg;

    // Sequencer state
    i2cm_pkg::seq_state_t state_reg, state_next;
    logic [7:0] hp_cnt_reg, hp_cnt_next;
    logic [3:0] bit_cnt_reg, bit_cnt_next;
    logic [7:0] shift_reg, shift_next;
    logic       ack_choice_reg, ack_choice_next;
    logic       ack_status_reg, ack_status_next;
    logic [7:0] rx_byte_reg, rx_byte_next;
    logic [1:0] drive_reg, drive_next;

    // Output stage
    i2cm_pkg::result_t out_reg, skid_reg, result;
    logic       out_valid_reg, skid_valid_reg;

    logic       s_accept, m_pop;
    logic       cmd_valid;
    logic [2:0] operation;
    logic       done, rej;

    assign cmd_valid = s_tuser[0];
    assign operation = s_tuser[3:1];
    assign s_accept  = s_tvalid && s_tready;
    assign m_pop     = out_valid_reg && m_tready;
    assign s_tready  = !skid_valid_reg;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_reg;

    // Line drive for a half period being entered
    function automatic logic [1:0] drive_for(
        input i2cm_pkg::seq_state_t st,
        input logic [3:0]           bits,
        input logic [7:0]           sh,
        input logic                 ac,
        input logic [1:0]           cur
    );
        logic [1:0] d;
        d = cur;
        unique case (st)
            i2cm_pkg::ST_START_A: d = i2cm_pkg::LD_NONE;
            i2cm_pkg::ST_START_B: d = i2cm_pkg::LD_SDA;
            i2cm_pkg::ST_RS_A:    d = i2cm_pkg::LD_SCL;
            i2cm_pkg::ST_RS_B:    d = i2cm_pkg::LD_NONE;
            i2cm_pkg::ST_RS_C:    d = i2cm_pkg::LD_SDA;
            i2cm_pkg::ST_STOP_A:  d = i2cm_pkg::LD_BOTH;
            i2cm_pkg::ST_STOP_B:  d = i2cm_pkg::LD_SDA;
            i2cm_pkg::ST_STOP_C:  d = i2cm_pkg::LD_NONE;
            i2cm_pkg::ST_WR_LOW, i2cm_pkg::ST_WR_HIGH: begin
                d = (st == i2cm_pkg::ST_WR_LOW) ? i2cm_pkg::LD_SCL : i2cm_pkg::LD_NONE;
                if (bits < i2cm_pkg::BITS_PER_BYTE && !sh[7]) d = d | i2cm_pkg::LD_SDA;
            end
            i2cm_pkg::ST_RD_LOW, i2cm_pkg::ST_RD_HIGH: begin
                d = (st == i2cm_pkg::ST_RD_LOW) ? i2cm_pkg::LD_SCL : i2cm_pkg::LD_NONE;
                if (bits >= i2cm_pkg::BITS_PER_BYTE && !ac) d = d | i2cm_pkg::LD_SDA;
            end
            default: d = cur;
        endcase
        return d;
    endfunction

    // Advance the sequencer by one tick
    always_comb begin
        state_next      = state_reg;
        hp_cnt_next     = hp_cnt_reg;
        bit_cnt_next    = bit_cnt_reg;
        shift_next      = shift_reg;
        ack_choice_next = ack_choice_reg;
        ack_status_next = ack_status_reg;
        rx_byte_next    = rx_byte_reg;
        drive_next      = drive_reg;
        done            = 1'b0;
        rej             = 1'b0;

        if (!enable_reg) begin
            // disabled: release the bus and drop any sequence
            state_next   = i2cm_pkg::ST_IDLE;
            hp_cnt_next  = '0;
            bit_cnt_next = '0;
            drive_next   = i2cm_pkg::LD_NONE;
            rej          = cmd_valid;
        end else if (state_reg != i2cm_pkg::ST_IDLE) begin
            rej = cmd_valid;
            if (hp_cnt_reg != '0) begin
                hp_cnt_next = hp_cnt_reg - 8'd1;
            end else begin
                // half period over: step to the next one or finish
                hp_cnt_next = divider_reg;
                unique case (state_reg)
                    i2cm_pkg::ST_START_A: state_next = i2cm_pkg::ST_START_B;
                    i2cm_pkg::ST_RS_A:    state_next = i2cm_pkg::ST_RS_B;
                    i2cm_pkg::ST_RS_B:    state_next = i2cm_pkg::ST_RS_C;
                    i2cm_pkg::ST_STOP_A:  state_next = i2cm_pkg::ST_STOP_B;
                    i2cm_pkg::ST_STOP_B:  state_next = i2cm_pkg::ST_STOP_C;
                    i2cm_pkg::ST_WR_LOW:  state_next = i2cm_pkg::ST_WR_HIGH;
                    i2cm_pkg::ST_RD_LOW:  state_next = i2cm_pkg::ST_RD_HIGH;
                    i2cm_pkg::ST_START_B, i2cm_pkg::ST_RS_C: begin
                        state_next = i2cm_pkg::ST_IDLE;
                        drive_next = i2cm_pkg::LD_BOTH;
                        done       = 1'b1;
                    end
                    i2cm_pkg::ST_STOP_C: begin
                        state_next = i2cm_pkg::ST_IDLE;
                        drive_next = i2cm_pkg::LD_NONE;
                        done       = 1'b1;
                    end
                    i2cm_pkg::ST_WR_HIGH: begin
                        if (bit_cnt_reg < i2cm_pkg::BITS_PER_BYTE) begin
                            shift_next   = {shift_reg[6:0], 1'b0};
                            bit_cnt_next = bit_cnt_reg + 4'd1;
                            state_next   = i2cm_pkg::ST_WR_LOW;
                        end else begin
                            ack_status_next = s_tdata[8];
                            state_next      = i2cm_pkg::ST_IDLE;
                            drive_next      = i2cm_pkg::LD_SCL;
                            done            = 1'b1;
                        end
                    end
                    i2cm_pkg::ST_RD_HIGH: begin
                        if (bit_cnt_reg < i2cm_pkg::BITS_PER_BYTE) begin
                            shift_next   = {shift_reg[6:0], s_tdata[8]};
                            bit_cnt_next = bit_cnt_reg + 4'd1;
                            state_next   = i2cm_pkg::ST_RD_LOW;
                        end else begin
                            rx_byte_next = shift_reg;
                            state_next   = i2cm_pkg::ST_IDLE;
                            drive_next   = i2cm_pkg::LD_SCL;
                            done         = 1'b1;
                        end
                    end
                    default: begin
                        state_next = i2cm_pkg::ST_IDLE;
                        drive_next = i2cm_pkg::LD_NONE;
                    end
                endcase
                if (state_next == i2cm_pkg::ST_IDLE) begin
                    hp_cnt_next  = '0;
                    bit_cnt_next = '0;
                end else begin
                    drive_next = drive_for(state_next, bit_cnt_next, shift_next,
                                           ack_choice_next, drive_reg);
                end
            end
        end else if (cmd_valid) begin
            // idle: decode a new command
            bit_cnt_next = '0;
            hp_cnt_next  = divider_reg;
            unique case (operation) inside
                i2cm_pkg::OP_START:   state_next = i2cm_pkg::ST_START_A;
                i2cm_pkg::OP_RESTART: state_next = i2cm_pkg::ST_RS_A;
                i2cm_pkg::OP_STOP:    state_next = i2cm_pkg::ST_STOP_A;
                i2cm_pkg::OP_WRITE: begin
                    shift_next = s_tdata[7:0];
                    state_next = i2cm_pkg::ST_WR_LOW;
                end
                i2cm_pkg::OP_READ_ACK, i2cm_pkg::OP_READ_NACK: begin
                    shift_next      = '0;
                    ack_choice_next = (operation == i2cm_pkg::OP_READ_NACK);
                    state_next      = i2cm_pkg::ST_RD_LOW;
                end
                default: begin
                    hp_cnt_next = hp_cnt_reg;
                    rej         = 1'b1;
                end
            endcase
            if (state_next != i2cm_pkg::ST_IDLE) begin
                drive_next = drive_for(state_next, bit_cnt_next, shift_next,
                                       ack_choice_next, drive_reg);
            end
        end

        result                  = '0;
        result.scl_drive_low    = drive_next[0];
        result.sda_drive_low    = drive_next[1];
        result.busy_res         = (state_next != i2cm_pkg::ST_IDLE);
        result.done_res         = done;
        result.not_acknowledged = ack_status_next;
        result.read_data        = rx_byte_next;
        result.command_rejected = rej;
    end

    // Hold configuration; writes beyond the register list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            divider_reg <= i2cm_pkg::DIVIDER_RESET;
            enable_reg  <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == i2cm_pkg::CFG_CLOCK_DIVIDER) divider_reg <= cfg_data;
            if (cfg_index == i2cm_pkg::CFG_ENABLE)        enable_reg  <= cfg_data[0];
        end
    end

    // Update the sequencer on each accepted tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= i2cm_pkg::ST_IDLE;
            hp_cnt_reg     <= '0;
            bit_cnt_reg    <= '0;
            shift_reg      <= '0;
            ack_choice_reg <= 1'b0;
            ack_status_reg <= 1'b0;
            rx_byte_reg    <= '0;
            drive_reg      <= i2cm_pkg::LD_NONE;
        end else if (s_accept) begin
            state_reg      <= state_next;
            hp_cnt_reg     <= hp_cnt_next;
            bit_cnt_reg    <= bit_cnt_next;
            shift_reg      <= shift_next;
            ack_choice_reg <= ack_choice_next;
            ack_status_reg <= ack_status_next;
            rx_byte_reg    <= rx_byte_next;
            drive_reg      <= drive_next;
        end
    end

    // Output register and skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (s_accept) begin
            if (!out_valid_reg || (m_pop && !skid_valid_reg)) begin
                out_valid_reg <= 1'b1;
            end else if (!m_pop) begin
                skid_valid_reg <= 1'b1;
            end
        end else if (m_pop) begin
            if (skid_valid_reg) begin
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            if (!out_valid_reg || (m_pop && !skid_valid_reg)) begin
                out_reg <= result;
            end else if (m_pop) begin
                out_reg  <= skid_reg;
                skid_reg <= result;
            end else begin
                skid_reg <= result;
            end
        end else if (m_pop && skid_valid_reg) begin
            out_reg <= skid_reg;
        end
    end

    // Checks
    `I2CM_ASSERT(a_skid_behind_out, !skid_valid_reg || out_valid_reg,
                 "skid entry holds a result while the output register is empty")
    `I2CM_ASSERT(a_idle_counters_clear,
                 state_reg != i2cm_pkg::ST_IDLE || (hp_cnt_reg == '0 && bit_cnt_reg == '0),
                 "idle sequencer left counters non-zero")
    `I2CM_ASSERT(a_bit_count_range, bit_cnt_reg <= i2cm_pkg::BITS_PER_BYTE,
                 "bit counter beyond one byte")
    `I2CM_ASSERT_NEXT(a_disable_to_idle, s_accept && !enable_reg,
                      state_reg == i2cm_pkg::ST_IDLE,
                      "disabled tick left a sequence running")
    `I2CM_ASSERT_NEXT(a_stall_fills_skid,
                      s_accept && out_valid_reg && !m_tready && !skid_valid_reg,
                      skid_valid_reg && out_valid_reg,
                      "stalled result not held in skid entry")

endmodule

`default_nettype wire

[tb/i2c_master_controller_core_tb.sv]
// ---------------------------------------------------------------------------
// I2C master controller core testbench
// Drives bus ticks and commands through the input stream, predicts every
// result with a tick-level model of the sequencer and checks each result
// field by field. Covers a directed table, then random bus transactions
// under several divider and enable settings, with random stalls on both
// sides and one long output hold-off that back-pressures the input.
// ---------------------------------------------------------------------------
module i2c_master_controller_core_tb;
    import i2cm_pkg::*;

    // Codes outside the command set, rejected even when idle
    localparam logic [2:0] OP_BAD_LO = 3'd6;
    localparam logic [2:0] OP_BAD_HI = 3'd7;

    localparam int DISABLED_ROWS = 3;
    localparam int NUM_PHASES    = 5;
    localparam int PRESSURE_PHASE = 1;
    localparam int HOLD_OFF_CYCLES = 200;

    typedef struct {
        logic       cv;
        logic [2:0] op;
        logic [7:0] wd;
        logic       sda;
        bit         settle;
        bit         typed;
        result_t    want;
    } tick_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic [3:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;

    // Predicted sequencer state and registers
    seq_state_t  p_state;
    logic [7:0]  p_count;
    logic [3:0]  p_bits;
    logic [7:0]  p_shift;
    logic        p_nack_sel;
    logic        p_ack_status;
    logic [7:0]  p_rx;
    logic [1:0]  p_lines;
    logic [7:0]  p_divider;
    logic        p_enable;
    logic        p_done;

    result_t     expected_bus_q[$];
    tick_row_t   directed_rows[$];

    bit gaps_on = 1'b0;
    bit bus_owned = 1'b0;
    bit hold_request = 1'b0;
    int rx_wait = 0;
    int error_count = 0;
    int results_seen = 0;
    int ticks_sent = 0;
    int cmds_taken = 0;
    int cmds_rejected = 0;
    int sequences_done = 0;
    int settings_used = 0;

    int phase_div[NUM_PHASES]    = '{0, 1, 1, 255, 3};
    int phase_en[NUM_PHASES]     = '{1, 1, 0, 1, 1};
    int phase_budget[NUM_PHASES] = '{450, 400, 60, 560, 350};
    bit phase_gaps[NUM_PHASES]   = '{1, 0, 1, 0, 1};

    i2c_master_controller_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Hard stop in case the block hangs
    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Line drive for the half period being entered
    function automatic logic [1:0] lines_for(seq_state_t st);
        logic [1:0] d;
        case (st)
            ST_START_A: d = LD_NONE;
            ST_START_B: d = LD_SDA;
            ST_RS_A:    d = LD_SCL;
            ST_RS_B:    d = LD_NONE;
            ST_RS_C:    d = LD_SDA;
            ST_STOP_A:  d = LD_BOTH;
            ST_STOP_B:  d = LD_SDA;
            ST_STOP_C:  d = LD_NONE;
            ST_WR_LOW, ST_WR_HIGH: begin
                d = (st == ST_WR_LOW) ? LD_SCL : LD_NONE;
                if (p_bits < BITS_PER_BYTE && !p_shift[7])
                    d = d | LD_SDA;
            end
            ST_RD_LOW, ST_RD_HIGH: begin
                d = (st == ST_RD_LOW) ? LD_SCL : LD_NONE;
                if (p_bits >= BITS_PER_BYTE && !p_nack_sel)
                    d = d | LD_SDA;
            end
            default: d = p_lines;
        endcase
        return d;
    endfunction

    function automatic void start_half(seq_state_t st);
        p_state = st;
        p_count = p_divider;
        p_lines = lines_for(st);
    endfunction

    function automatic void end_sequence(logic [1:0] final_lines);
        p_state = ST_IDLE;
        p_count = '0;
        p_bits  = '0;
        p_lines = final_lines;
        p_done  = 1'b1;
    endfunction

    // Move on once the current half period has run out
    function automatic void next_half(logic sda);
        case (p_state)
            ST_START_A: start_half(ST_START_B);
            ST_START_B: end_sequence(LD_BOTH);
            ST_RS_A:    start_half(ST_RS_B);
            ST_RS_B:    start_half(ST_RS_C);
            ST_RS_C:    end_sequence(LD_BOTH);
            ST_STOP_A:  start_half(ST_STOP_B);
            ST_STOP_B:  start_half(ST_STOP_C);
            ST_STOP_C:  end_sequence(LD_NONE);
            ST_WR_LOW:  start_half(ST_WR_HIGH);
            ST_WR_HIGH: begin
                if (p_bits < BITS_PER_BYTE) begin
                    p_shift = {p_shift[6:0], 1'b0};
                    p_bits  = p_bits + 4'd1;
                    start_half(ST_WR_LOW);
                end else begin
                    p_ack_status = sda;
                    end_sequence(LD_SCL);
                end
            end
            ST_RD_LOW:  start_half(ST_RD_HIGH);
            ST_RD_HIGH: begin
                if (p_bits < BITS_PER_BYTE) begin
                    p_shift = {p_shift[6:0], sda};
                    p_bits  = p_bits + 4'd1;
                    start_half(ST_RD_LOW);
                end else begin
                    p_rx = p_shift;
                    end_sequence(LD_SCL);
                end
            end
            default: begin
                end_sequence(LD_NONE);
                p_done = 1'b0;
            end
        endcase
    endfunction

    // Advance the predicted controller by one tick and return its result
    function automatic result_t bus_tick_model(logic cv, logic [2:0] op, logic [7:0] wd,
                                               logic sda);
        result_t r;
        logic    rej;
        rej    = 1'b0;
        p_done = 1'b0;
        if (!p_enable) begin
            p_state = ST_IDLE;
            p_count = '0;
            p_bits  = '0;
            p_lines = LD_NONE;
            rej     = cv;
        end else if (p_state != ST_IDLE) begin
            rej = cv;
            if (p_count != 8'd0)
                p_count = p_count - 8'd1;
            else
                next_half(sda);
        end else if (cv) begin
            p_bits = '0;
            case (op)
                OP_START:   start_half(ST_START_A);
                OP_RESTART: start_half(ST_RS_A);
                OP_STOP:    start_half(ST_STOP_A);
                OP_WRITE: begin
                    p_shift = wd;
                    start_half(ST_WR_LOW);
                end
                OP_READ_ACK, OP_READ_NACK: begin
                    p_shift    = '0;
                    p_nack_sel = (op == OP_READ_NACK);
                    start_half(ST_RD_LOW);
                end
                default: rej = 1'b1;
            endcase
        end
        r = '0;
        r.scl_drive_low    = (p_lines & LD_SCL) != LD_NONE;
        r.sda_drive_low    = (p_lines & LD_SDA) != LD_NONE;
        r.busy_res         = (p_state != ST_IDLE);
        r.done_res         = p_done;
        r.not_acknowledged = p_ack_status;
        r.read_data        = p_rx;
        r.command_rejected = rej;
        return r;
    endfunction

    function automatic tick_row_t make_row(logic cv, logic [2:0] op, logic [7:0] wd,
                                           logic sda, bit settle, bit typed, result_t want);
        tick_row_t t;
        t.cv = cv;
        t.op = op;
        t.wd = wd;
        t.sda = sda;
        t.settle = settle;
        t.typed = typed;
        t.want = want;
        return t;
    endfunction

    // Offer one tick request, wait for it to be taken, then predict its result
    task automatic send_tick(input logic cv, input logic [2:0] op, input logic [7:0] wd,
                             input logic sda, input bit typed, input result_t want);
        int      gap;
        result_t predicted;
        gap = gaps_on ? $urandom_range(0, 14) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {op, cv};
        s_tdata  <= {7'd0, sda, wd};
        do @(posedge aclk); while (!s_tready);
        predicted = bus_tick_model(cv, op, wd, sda);
        expected_bus_q.push_back(typed ? want : predicted);
        ticks_sent++;
        if (predicted.command_rejected)
            cmds_rejected++;
        else if (cv && p_enable)
            cmds_taken++;
        if (predicted.done_res)
            sequences_done++;
    endtask

    // Drop the input request and let every pending result come out
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_bus_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_CLOCK_DIVIDER)
            p_divider = val;
        else if (idx == CFG_ENABLE)
            p_enable = val[0];
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Random bus traffic: mostly well-formed transactions, some stray commands
    task automatic run_phase(input int budget);
        int         first;
        int         roll;
        logic [2:0] op;
        first = ticks_sent;
        while (ticks_sent - first < budget) begin
            if (!p_enable) begin
                send_tick(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                          8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, '0);
            end else if (p_state == ST_IDLE && $urandom_range(0, 2) != 0) begin
                roll = $urandom_range(0, 19);
                if (roll == 0)
                    op = $urandom_range(0, 1) ? OP_BAD_HI : OP_BAD_LO;
                else if (!bus_owned && roll == 1)
                    op = 3'($urandom_range(0, 5));
                else if (!bus_owned)
                    op = OP_START;
                else if (roll < 9)
                    op = OP_WRITE;
                else if (roll < 13)
                    op = OP_READ_ACK;
                else if (roll < 16)
                    op = OP_READ_NACK;
                else if (roll < 18)
                    op = OP_RESTART;
                else
                    op = OP_STOP;
                if (op == OP_START || op == OP_RESTART)
                    bus_owned = 1'b1;
                else if (op == OP_STOP)
                    bus_owned = 1'b0;
                send_tick(1'b1, op, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          1'b0, '0);
            end else begin
                send_tick($urandom_range(0, 7) == 0, 3'($urandom_range(0, 7)),
                          8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, '0);
            end
        end
    endtask

    // Output side: random stalls per result, plus one long hold-off on request
    initial begin : result_receiver
        int held;
        held = 0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                held = HOLD_OFF_CYCLES;
            end
            if (held > 0) begin
                held--;
                m_tready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic flag_field(input string name, input logic [7:0] want, input logic [7:0] got);
        error_count++;
        if (error_count <= 10)
            $display("result %0d: %s expected %h, got %h", results_seen, name, want, got);
    endtask

    // Compare each taken result with the oldest prediction
    always @(posedge aclk) begin : result_check
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (expected_bus_q.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("result %0d arrived with nothing pending: %h", results_seen, got);
            end else begin
                want = expected_bus_q.pop_front();
                if (got.scl_drive_low !== want.scl_drive_low)
                    flag_field("scl_drive_low", 8'(want.scl_drive_low),
                               8'(got.scl_drive_low));
                if (got.sda_drive_low !== want.sda_drive_low)
                    flag_field("sda_drive_low", 8'(want.sda_drive_low),
                               8'(got.sda_drive_low));
                if (got.busy_res !== want.busy_res)
                    flag_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
                if (got.done_res !== want.done_res)
                    flag_field("done_res", 8'(want.done_res), 8'(got.done_res));
                if (got.not_acknowledged !== want.not_acknowledged)
                    flag_field("not_acknowledged", 8'(want.not_acknowledged),
                               8'(got.not_acknowledged));
                if (got.read_data !== want.read_data)
                    flag_field("read_data", want.read_data, got.read_data);
                if (got.command_rejected !== want.command_rejected)
                    flag_field("command_rejected", 8'(want.command_rejected),
                               8'(got.command_rejected));
            end
            results_seen++;
            rx_wait = gaps_on ? $urandom_range(0, 14) : 0;
        end
    end

    initial begin : stimulus
        result_t   rej_only;
        tick_row_t row;

        // Predictor state after reset
        p_state      = ST_IDLE;
        p_count      = '0;
        p_bits       = '0;
        p_shift      = '0;
        p_nack_sel   = 1'b0;
        p_ack_status = 1'b0;
        p_rx         = '0;
        p_lines      = LD_NONE;
        p_divider    = DIVIDER_RESET;
        p_enable     = 1'b0;
        p_done       = 1'b0;

        rej_only = '0;
        rej_only.command_rejected = 1'b1;

        // Out of reset the controller is disabled: commands bounce, lines stay free
        directed_rows.push_back(make_row(1'b1, OP_START, 8'h00, 1'b0, 1'b0, 1'b1, rej_only));
        directed_rows.push_back(make_row(1'b1, OP_BAD_HI, 8'hFF, 1'b1, 1'b0, 1'b1, rej_only));
        directed_rows.push_back(make_row(1'b0, OP_WRITE, 8'h5A, 1'b1, 1'b0, 1'b1, '0));
        // Enabled, fastest divider
        directed_rows.push_back(make_row(1'b1, OP_BAD_LO, 8'h00, 1'b0, 1'b0, 1'b0, '0));
        directed_rows.push_back(make_row(1'b1, OP_BAD_HI, 8'h00, 1'b0, 1'b0, 1'b0, '0));
        directed_rows.push_back(make_row(1'b1, OP_START, 8'h00, 1'b0, 1'b0, 1'b0, '0));
        // Commands mid-sequence and on the finishing tick are both refused
        directed_rows.push_back(make_row(1'b1, OP_WRITE, 8'hA5, 1'b0, 1'b0, 1'b0, '0));
        directed_rows.push_back(make_row(1'b1, OP_WRITE, 8'hA5, 1'b0, 1'b1, 1'b0, '0));
        // Write all ones with a NACK, then all zeros with an ACK
        directed_rows.push_back(make_row(1'b1, OP_WRITE, 8'hFF, 1'b1, 1'b1, 1'b0, '0));
        directed_rows.push_back(make_row(1'b1, OP_WRITE, 8'h00, 1'b0, 1'b1, 1'b0, '0));
        // Reads leave the ack status alone
        directed_rows.push_back(make_row(1'b1, OP_READ_ACK, 8'h00, 1'b1, 1'b1, 1'b0, '0));
        directed_rows.push_back(make_row(1'b1, OP_RESTART, 8'h00, 1'b1, 1'b1, 1'b0, '0));
        directed_rows.push_back(make_row(1'b1, OP_READ_NACK, 8'hFF, 1'b0, 1'b1, 1'b0, '0));
        directed_rows.push_back(make_row(1'b1, OP_WRITE, 8'h3C, 1'b1, 1'b1, 1'b0, '0));
        directed_rows.push_back(make_row(1'b1, OP_STOP, 8'h00, 1'b0, 1'b1, 1'b0, '0));
        directed_rows.push_back(make_row(1'b0, OP_BAD_HI, 8'hFF, 1'b1, 1'b0, 1'b0, '0));

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        gaps_on = 1'b1;
        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (i == DISABLED_ROWS) begin
                drain_results();
                write_reg(CFG_CLOCK_DIVIDER, 8'd0);
                write_reg(CFG_ENABLE, 8'd1);
                settings_used++;
            end
            send_tick(row.cv, row.op, row.wd, row.sda, row.typed, row.want);
            // Idle ticks until the sequence ends, holding SDA at the row's level
            if (row.settle) begin
                while (p_state != ST_IDLE)
                    send_tick(1'b0, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                              row.sda, 1'b0, '0);
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain_results();
            write_reg(CFG_CLOCK_DIVIDER, 8'(phase_div[ph]));
            write_reg(CFG_ENABLE, 8'(phase_en[ph]));
            settings_used++;
            if (!p_enable)
                bus_owned = 1'b0;
            gaps_on = phase_gaps[ph];
            if (ph == PRESSURE_PHASE)
                hold_request = 1'b1;
            run_phase(phase_budget[ph]);
        end

        drain_results();
        repeat (20) @(posedge aclk);
        if (expected_bus_q.size() != 0) begin
            error_count++;
            $display("%0d results never arrived", expected_bus_q.size());
        end
        $display("Ran %0d ticks over %0d register settings, %0d mismatches", ticks_sent,
                 settings_used, error_count);
        $display("Commands taken %0d, refused %0d, sequences completed %0d", cmds_taken,
                 cmds_rejected, sequences_done);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/i2cm_pkg.sv
hw/rtl/i2c_master_controller_core.sv
tb/i2c_master_controller_core_tb.sv
